// File: sv/lisl_pkg.sv
// Shared constants and controller/datapath interface types for the LIS length block.
package lisl_pkg;

    localparam int DATA_W        = 32;
    localparam int LEN_W         = 9;
    localparam int OUT_TDATA_W   = 16;
    localparam int DEPTH_DEFAULT = 256;

    typedef struct packed {
        logic load;   // take in a new item, set up the search range
        logic step;   // one binary search probe: narrow the range
        logic write;  // commit the tail replace or append
        logic emit;   // load the result register
    } lisl_cmd_t;

    typedef struct packed {
        logic range_empty;  // lo >= hi in the current range
        logic step_done;    // range becomes empty after this probe
        logic out_free;     // result register can take a new item
    } lisl_status_t;

endpackage

// File: sv/lisl_ctrl.sv
// Sequencer for one item: search set-up, probe loop, table update, result hand-off.
module lisl_ctrl
    import lisl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_fire,
    input  lisl_status_t status,
    output lisl_cmd_t    cmd,
    output logic         idle
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FIRST = 3'd1;
    localparam logic [2:0] S_STEP  = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        idle       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                idle = 1'b1;
                if (in_fire)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_FIRST;
                end
            end
            S_FIRST:
            begin
                // read of the first midpoint was issued on load
                state_next = status.range_empty ? S_WRITE : S_STEP;
            end
            S_STEP:
            begin
                cmd.step = 1'b1;
                if (status.step_done)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.write  = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: sv/lisl_dp.sv
// Datapath: tails RAM, search range, tail count, overflow flag and result register.
module lisl_dp
    import lisl_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  lisl_cmd_t                cmd,
    output lisl_status_t             status,
    input  logic signed [DATA_W-1:0] in_value,
    input  logic                     in_start,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [LEN_W-1:0]         out_length,
    output logic                     out_overflow
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    logic signed [DATA_W-1:0] tails [TABLE_DEPTH];

    logic signed [DATA_W-1:0] key_reg;
    logic signed [DATA_W-1:0] rd_data_reg;
    logic [CNT_W-1:0]         lo_reg, lo_next;
    logic [CNT_W-1:0]         hi_reg, hi_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     ovf_reg, ovf_next;
    logic                     out_valid_reg, out_valid_next;
    logic [LEN_W-1:0]         out_length_reg;
    logic                     out_overflow_reg;
    logic [CNT_W-1:0]         mid_cur;
    logic [CNT_W-1:0]         mid_next;
    logic                     wr_en;

    assign mid_cur  = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign mid_next = lo_next + ((hi_next - lo_next) >> 1);

    always_comb
    begin
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        wr_en      = 1'b0;
        if (cmd.load)
        begin
            lo_next = '0;
            if (in_start)
            begin
                hi_next    = '0;
                count_next = '0;
                ovf_next   = 1'b0;
            end
            else
            begin
                hi_next = count_reg;
            end
        end
        if (cmd.step)
        begin
            if (rd_data_reg < key_reg)
            begin
                lo_next = mid_cur + 1'b1;
            end
            else
            begin
                hi_next = mid_cur;
            end
        end
        if (cmd.write)
        begin
            // search ran off the end: key is above every tail, so append, or set overflow if the table is full
            if (lo_reg == count_reg)
            begin
                if (count_reg < DEPTH_C)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            else
            begin
                wr_en = 1'b1;
            end
        end
    end

    // tails RAM: one write port, one registered read port fed by the next midpoint
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tails[lo_reg[ADDR_W-1:0]] <= key_reg;
        end
        rd_data_reg <= tails[mid_next[ADDR_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg <= in_value;
        end
        if (cmd.emit)
        begin
            out_length_reg   <= LEN_W'(count_reg);
            out_overflow_reg <= ovf_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg        <= '0;
            hi_reg        <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign status.range_empty = (lo_reg >= hi_reg);
    assign status.step_done   = (lo_next >= hi_next);
    assign status.out_free    = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign out_length   = out_length_reg;
    assign out_overflow = out_overflow_reg;

endmodule

// File: sv/longest_increasing_subsequence_length.sv
// Top level of the streaming longest strictly increasing subsequence length block.
//
// Each item carries one signed 32-bit element and a start flag; the block
// keeps the patience-method tails table in a RAM of TABLE_DEPTH words and
// returns one result per item: the running subsequence length and a sticky
// overflow flag (an append was dropped because the table was full). The
// binary search makes one probe per cycle through the tails RAM's registered
// read port. The next item is taken as soon as the result is in the output
// register, whether or not it has been collected yet. After reset the table
// is empty; the start flag empties it before its own element.
module longest_increasing_subsequence_length
    import lisl_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [DATA_W-1:0]      s_tdata,   // [31:0] value
    input  logic                   s_tuser,   // [0] start_req
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // [8:0] length, [9] overflow, rest zero
);

    lisl_cmd_t    cmd;
    lisl_status_t status;
    logic         idle;
    logic         in_fire;
    logic [LEN_W-1:0] length;
    logic         overflow;

    assign s_tready = idle;
    assign in_fire  = s_tvalid && idle;

    lisl_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .status  (status),
        .cmd     (cmd),
        .idle    (idle)
    );

    lisl_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .in_value     ($signed(s_tdata)),
        .in_start     (s_tuser),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_length   (length),
        .out_overflow (overflow)
    );

    assign m_tdata = {{(OUT_TDATA_W - LEN_W - 1){1'b0}}, overflow, length};

endmodule
